FILE: src/nbgs_pkg.sv
`timescale 1ns / 1ps
package nbgs_pkg;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAV    = 3'd0,
    CFG_SOFT    = 3'd1,
    CFG_REST    = 3'd2,
    CFG_WIDTH   = 3'd3,
    CFG_HEIGHT  = 3'd4,
    CFG_COUNT   = 3'd5
  } cfg_idx_t;

  localparam int DIV_W   = 64;
  localparam int ROOT_W  = 32;
  localparam int SQ_IN_W = 2 * ROOT_W;
  localparam int ACC_W   = 40;

  localparam logic [ACC_W-1:0]  FORCE_CAP = 40'hFF_FFFF_FFFF;
  localparam logic signed [42:0] ACC_LIM  = 43'sh7F_FFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [31:0]        mass;
    logic [31:0]        size_x;
    logic [31:0]        size_y;
  } body_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [42:0] v);
    logic signed [ACC_W-1:0] res;
    if (v > ACC_LIM) begin
      res = ACC_W'(ACC_LIM);
    end else if (v < -ACC_LIM) begin
      res = ACC_W'(-ACC_LIM);
    end else begin
      res = v[ACC_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: src/nbgs_ram.sv
`timescale 1ns / 1ps
module nbgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/nbgs_div.sv
`timescale 1ns / 1ps
module nbgs_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [nbgs_pkg::DIV_W-1:0] dividend,
  input  logic [nbgs_pkg::DIV_W-1:0] divisor,
  output logic                       done,
  output logic [nbgs_pkg::DIV_W-1:0] quotient
);
  import nbgs_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W-1:0] q_r, q_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DIV_W:0]   shifted;
  logic             fits;

  always_comb begin
    shifted = {rem_r, q_r[DIV_W-1]};
    fits    = shifted >= {1'b0, dvs_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '1;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? DIV_W'(shifted - {1'b0, dvs_r}) : shifted[DIV_W-1:0];
      q_nxt   = {q_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: src/nbgs_sqrt.sv
`timescale 1ns / 1ps
module nbgs_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [nbgs_pkg::SQ_IN_W-1:0] operand,
  output logic                         done,
  output logic [nbgs_pkg::ROOT_W-1:0]  root
);
  import nbgs_pkg::*;

  localparam logic [SQ_IN_W-1:0] BIT0 = {2'b01, {(SQ_IN_W-2){1'b0}}};

  logic [SQ_IN_W-1:0] v_r, v_nxt;
  logic [SQ_IN_W-1:0] r_r, r_nxt;
  logic [SQ_IN_W-1:0] bit_r, bit_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [SQ_IN_W-1:0] trial;

  always_comb begin
    trial    = r_r + bit_r;
    v_nxt    = v_r;
    r_nxt    = r_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      v_nxt    = operand;
      r_nxt    = '0;
      bit_nxt  = BIT0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_nxt = v_r - trial;
        r_nxt = (r_r >> 1) + bit_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign root = r_r[ROOT_W-1:0];

endmodule

FILE: src/nbody_gravity_step.sv
`timescale 1ns / 1ps
// Softened direct-sum gravity step over up to MAX_BODIES bodies in fixed point.
// A load item with an index in range writes one body slot. A step item first sums, for
// every body in use, the pull of every other body from the old positions, one
// ordered pair at a time: a 32-step square root and three 64-step divisions on
// one shared divider; a pair whose root is zero adds nothing. The sums go to an
// acceleration memory, then each body is integrated, clamped to the walls and
// emits its result, waiting while the output is stalled. No item is taken
// until the last result is issued.
module nbody_gravity_step #(
  parameter int MAX_BODIES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_kind,
  input  logic [3:0]                           in_body_index,
  input  logic signed [31:0]                   in_load_pos_x,
  input  logic signed [31:0]                   in_load_pos_y,
  input  logic signed [31:0]                   in_load_vel_x,
  input  logic signed [31:0]                   in_load_vel_y,
  input  logic [31:0]                          in_load_mass,
  input  logic [31:0]                          in_load_size_x,
  input  logic [31:0]                          in_load_size_y,
  input  logic [23:0]                          in_time_delta,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [3:0]                           out_index,
  output logic signed [31:0]                   out_pos_x,
  output logic signed [31:0]                   out_pos_y,
  output logic signed [31:0]                   out_vel_x,
  output logic signed [31:0]                   out_vel_y,
  output logic                                 out_last_body,
  input  logic                                 cfg_we,
  input  logic [nbgs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_wdata
);
  import nbgs_pkg::*;

  localparam int IW = $clog2(MAX_BODIES);
  localparam int NW = $clog2(MAX_BODIES + 1);
  localparam logic [7:0] MAXB = 8'(MAX_BODIES);
  localparam int BW = $bits(body_t);

  typedef enum logic [19:0] {
    S_IDLE = 20'h00001,
    S_RDI  = 20'h00002,
    S_LATI = 20'h00004,
    S_RDJ  = 20'h00008,
    S_LATJ = 20'h00010,
    S_SQ   = 20'h00020,
    S_SQGO = 20'h00040,
    S_SQW  = 20'h00080,
    S_DF   = 20'h00100,
    S_DUX  = 20'h00200,
    S_DUY  = 20'h00400,
    S_TERM = 20'h00800,
    S_ACC  = 20'h01000,
    S_WACC = 20'h02000,
    S_URD  = 20'h04000,
    S_U1   = 20'h08000,
    S_U2   = 20'h10000,
    S_U3   = 20'h20000,
    S_U4   = 20'h40000,
    S_U5   = 20'h80000
  } state_t;

  // config
  logic [31:0] grav_r, soft_r;
  logic [16:0] rest_r;
  logic [15:0] aw_r, ah_r;
  logic [4:0]  bc_r;

  state_t          state_r, state_nxt;
  logic [NW-1:0]   n_r, n_nxt, i_r, i_nxt, j_r, j_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            u6_r, u6_nxt;

  logic [23:0]     dt_r;
  logic signed [31:0] pix_r, piy_r;
  logic [31:0]     ax_r, ay_r, mass_r;
  logic            sx_r, sy_r;
  logic [48:0]     d2_r;
  logic [63:0]     gm_r;
  logic [32:0]     dist_r;
  logic [39:0]     f_r;
  logic [16:0]     ux_r, uy_r;
  logic [40:0]     tx_r, ty_r;
  logic signed [ACC_W-1:0] accx_r, accy_r;

  body_t           bd_r;
  logic [38:0]     mx_r, my_r;
  logic            sgx_r, sgy_r;
  logic signed [31:0] vx_r, vy_r, px_r, py_r, npx_r, npy_r;
  logic [31:0]     mvx_r, mvy_r;
  logic [32:0]     rpx_r, rpy_r;
  logic            hitx_r, hity_r;

  logic [3:0]      out_index_r;
  logic signed [31:0] out_pos_x_r, out_pos_y_r, out_vel_x_r, out_vel_y_r;
  logic            out_last_r;

  // memories and units
  logic            body_we;
  logic [IW-1:0]   body_waddr, body_raddr;
  body_t           body_wdata, body_rd;
  logic [BW-1:0]   body_rd_bits;
  logic            acc_we;
  logic [2*ACC_W-1:0] acc_rd;
  logic            sq_start, sq_done;
  logic [ROOT_W-1:0] sq_root;
  logic            div_start, div_done;
  logic [DIV_W-1:0] div_a, div_b, div_q;

  // datapath temporaries
  logic [7:0]      n8;
  logic            load_ok, out_free, last_i;
  body_t           load_entry, upd_entry;
  logic signed [32:0] dxw, dyw;
  logic [31:0]     adx, ady;
  logic [63:0]     sqx, sqy;
  logic [48:0]     d2_w;
  logic [39:0]     f_w;
  logic [16:0]     u_w;
  logic [56:0]     tpx, tpy;
  logic signed [42:0] termx, termy, sumx, sumy;
  logic signed [ACC_W-1:0] ain_x, ain_y;
  logic [ACC_W-1:0] magx, magy;
  logic [63:0]     mulax, mulay;
  logic signed [40:0] vsx, vsy;
  logic [31:0]     avx, avy;
  logic [63:0]     mulvx, mulvy;
  logic signed [33:0] psx, psy;
  logic signed [34:0] hsx, hsy, wx, wy, wmx, wmy;
  logic            hix, hiy, lox, loy;
  logic [48:0]     rmx, rmy;
  logic signed [33:0] rvx, rvy;
  logic signed [31:0] vfx, vfy;

  assign body_rd = body_t'(body_rd_bits);

  nbgs_ram #(.WIDTH(BW), .DEPTH(MAX_BODIES)) u_body_ram (
    .clk   (clk),
    .we    (body_we),
    .waddr (body_waddr),
    .wdata (BW'(body_wdata)),
    .raddr (body_raddr),
    .rdata (body_rd_bits)
  );

  nbgs_ram #(.WIDTH(2*ACC_W), .DEPTH(MAX_BODIES)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (i_r[IW-1:0]),
    .wdata ({accx_r, accy_r}),
    .raddr (i_r[IW-1:0]),
    .rdata (acc_rd)
  );

  nbgs_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .operand ({1'b0, d2_r, 14'b0}),
    .done    (sq_done),
    .root    (sq_root)
  );

  nbgs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    // step size and load slot
    if (bc_r == 5'd0) begin
      n8 = 8'd1;
    end else if ({3'b0, bc_r} > MAXB) begin
      n8 = MAXB;
    end else begin
      n8 = {3'b0, bc_r};
    end
    load_ok  = {4'b0, in_body_index} < MAXB;
    out_free = !out_valid_r || !out_stall;
    last_i   = (i_r + 1'b1) == n_r;

    load_entry = '{pos_x: in_load_pos_x, pos_y: in_load_pos_y,
                   vel_x: in_load_vel_x, vel_y: in_load_vel_y,
                   mass: in_load_mass, size_x: in_load_size_x,
                   size_y: in_load_size_y};

    // pair terms
    dxw = 33'(body_rd.pos_x) - 33'(pix_r);
    dyw = 33'(body_rd.pos_y) - 33'(piy_r);
    adx = dxw[32] ? 32'(-dxw) : dxw[31:0];
    ady = dyw[32] ? 32'(-dyw) : dyw[31:0];
    sqx = ax_r * ax_r;
    sqy = ay_r * ay_r;
    d2_w = {1'b0, sqx[63:16]} + {1'b0, sqy[63:16]};
    f_w = (div_q[63:40] != '0) ? FORCE_CAP : div_q[39:0];
    u_w = (div_q > 64'd65536) ? 17'd65536 : div_q[16:0];
    tpx = f_r * ux_r;
    tpy = f_r * uy_r;
    termx = {2'b00, tx_r};
    termy = {2'b00, ty_r};
    sumx = 43'(accx_r) + (sx_r ? -termx : termx);
    sumy = 43'(accy_r) + (sy_r ? -termy : termy);

    // integration
    ain_x = acc_rd[2*ACC_W-1:ACC_W];
    ain_y = acc_rd[ACC_W-1:0];
    magx  = ain_x[ACC_W-1] ? ACC_W'(-ain_x) : ain_x;
    magy  = ain_y[ACC_W-1] ? ACC_W'(-ain_y) : ain_y;
    mulax = magx * dt_r;
    mulay = magy * dt_r;
    vsx = 41'(bd_r.vel_x) + (sgx_r ? -41'(mx_r) : 41'(mx_r));
    vsy = 41'(bd_r.vel_y) + (sgy_r ? -41'(my_r) : 41'(my_r));
    avx = vx_r[31] ? 32'(-vx_r) : vx_r;
    avy = vy_r[31] ? 32'(-vy_r) : vy_r;
    mulvx = avx * dt_r;
    mulvy = avy * dt_r;
    psx = 34'(bd_r.pos_x) + (vx_r[31] ? -34'(mvx_r) : 34'(mvx_r));
    psy = 34'(bd_r.pos_y) + (vy_r[31] ? -34'(mvy_r) : 34'(mvy_r));

    // walls
    wx  = {3'b0, aw_r, 16'b0};
    wy  = {3'b0, ah_r, 16'b0};
    hsx = 35'(px_r) + $signed({3'b0, bd_r.size_x});
    hsy = 35'(py_r) + $signed({3'b0, bd_r.size_y});
    wmx = wx - $signed({3'b0, bd_r.size_x});
    wmy = wy - $signed({3'b0, bd_r.size_y});
    hix = hsx >= wx;
    hiy = hsy >= wy;
    lox = px_r <= 32'sd0;
    loy = py_r <= 32'sd0;
    rmx = avx * rest_r;
    rmy = avy * rest_r;
    rvx = vx_r[31] ? 34'(rpx_r) : -34'(rpx_r);
    rvy = vy_r[31] ? 34'(rpy_r) : -34'(rpy_r);
    vfx = hitx_r ? sat32(64'(rvx)) : vx_r;
    vfy = hity_r ? sat32(64'(rvy)) : vy_r;

    upd_entry = '{pos_x: npx_r, pos_y: npy_r, vel_x: vfx, vel_y: vfy,
                  mass: bd_r.mass, size_x: bd_r.size_x, size_y: bd_r.size_y};
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    n_nxt      = n_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    u6_nxt     = u6_r;
    body_we    = 1'b0;
    body_waddr = i_r[IW-1:0];
    body_wdata = upd_entry;
    body_raddr = (state_r == S_RDJ) ? j_r[IW-1:0] : i_r[IW-1:0];
    acc_we     = 1'b0;
    sq_start   = 1'b0;
    div_start  = 1'b0;
    div_a      = gm_r;
    div_b      = 64'(d2_r) + 64'(soft_r);
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;

    if (u6_r) begin
      if (out_free) begin
        body_we       = 1'b1;
        out_valid_nxt = 1'b1;
        u6_nxt        = 1'b0;
        if (last_i) begin
          state_nxt = S_IDLE;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_URD;
        end
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (!in_kind) begin
              body_we    = load_ok;
              body_waddr = IW'(in_body_index);
              body_wdata = load_entry;
            end else begin
              n_nxt     = NW'(n8);
              i_nxt     = '0;
              state_nxt = S_RDI;
            end
          end
        end
        S_RDI:  state_nxt = S_LATI;
        S_LATI: begin
          j_nxt     = '0;
          state_nxt = S_RDJ;
        end
        S_RDJ: begin
          if (j_r == n_r) begin
            state_nxt = S_WACC;
          end else if (j_r == i_r) begin
            j_nxt = j_r + 1'b1;
          end else begin
            state_nxt = S_LATJ;
          end
        end
        S_LATJ: state_nxt = S_SQ;
        S_SQ:   state_nxt = S_SQGO;
        S_SQGO: begin
          sq_start  = 1'b1;
          state_nxt = S_SQW;
        end
        S_SQW: begin
          if (sq_done) begin
            if (sq_root == '0) begin
              j_nxt     = j_r + 1'b1;
              state_nxt = S_RDJ;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DF;
            end
          end
        end
        S_DF: begin
          div_a = {16'b0, ax_r, 16'b0};
          div_b = 64'(dist_r);
          if (div_done) begin
            div_start = 1'b1;
            state_nxt = S_DUX;
          end
        end
        S_DUX: begin
          div_a = {16'b0, ay_r, 16'b0};
          div_b = 64'(dist_r);
          if (div_done) begin
            div_start = 1'b1;
            state_nxt = S_DUY;
          end
        end
        S_DUY: begin
          if (div_done) begin
            state_nxt = S_TERM;
          end
        end
        S_TERM: state_nxt = S_ACC;
        S_ACC: begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_RDJ;
        end
        S_WACC: begin
          acc_we = 1'b1;
          if (last_i) begin
            i_nxt     = '0;
            state_nxt = S_URD;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_RDI;
          end
        end
        S_URD: state_nxt = S_U1;
        S_U1:  state_nxt = S_U2;
        S_U2:  state_nxt = S_U3;
        S_U3:  state_nxt = S_U4;
        S_U4:  state_nxt = S_U5;
        S_U5:  u6_nxt    = 1'b1;
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      u6_r        <= 1'b0;
      out_valid_r <= 1'b0;
      grav_r      <= 32'd65536000;
      soft_r      <= 32'd327680000;
      rest_r      <= 17'd52429;
      aw_r        <= 16'd970;
      ah_r        <= 16'd1000;
      bc_r        <= 5'd3;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      u6_r        <= u6_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GRAV:   grav_r <= cfg_wdata;
          CFG_SOFT:   soft_r <= cfg_wdata;
          CFG_REST:   rest_r <= cfg_wdata[16:0];
          CFG_WIDTH:  aw_r   <= cfg_wdata[15:0];
          CFG_HEIGHT: ah_r   <= cfg_wdata[15:0];
          CFG_COUNT:  bc_r   <= cfg_wdata[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (u6_r && out_free) begin
      out_index_r <= 4'(i_r);
      out_pos_x_r <= npx_r;
      out_pos_y_r <= npy_r;
      out_vel_x_r <= vfx;
      out_vel_y_r <= vfy;
      out_last_r  <= last_i;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_kind) begin
          dt_r <= in_time_delta;
        end
      end
      S_LATI: begin
        pix_r  <= body_rd.pos_x;
        piy_r  <= body_rd.pos_y;
        accx_r <= '0;
        accy_r <= '0;
      end
      S_LATJ: begin
        ax_r   <= adx;
        ay_r   <= ady;
        sx_r   <= dxw[32];
        sy_r   <= dyw[32];
        mass_r <= body_rd.mass;
      end
      S_SQ: begin
        d2_r <= d2_w;
        gm_r <= grav_r * mass_r;
      end
      S_SQW: dist_r <= {sq_root, 1'b0};
      S_DF: begin
        if (div_done) begin
          f_r <= f_w;
        end
      end
      S_DUX: begin
        if (div_done) begin
          ux_r <= u_w;
        end
      end
      S_DUY: begin
        if (div_done) begin
          uy_r <= u_w;
        end
      end
      S_TERM: begin
        tx_r <= tpx[56:16];
        ty_r <= tpy[56:16];
      end
      S_ACC: begin
        accx_r <= sat_acc(sumx);
        accy_r <= sat_acc(sumy);
      end
      S_U1: begin
        bd_r  <= body_rd;
        mx_r  <= mulax[62:24];
        my_r  <= mulay[62:24];
        sgx_r <= ain_x[ACC_W-1];
        sgy_r <= ain_y[ACC_W-1];
      end
      S_U2: begin
        vx_r <= sat32(64'(vsx));
        vy_r <= sat32(64'(vsy));
      end
      S_U3: begin
        mvx_r <= mulvx[55:24];
        mvy_r <= mulvy[55:24];
      end
      S_U4: begin
        px_r <= sat32(64'(psx));
        py_r <= sat32(64'(psy));
      end
      S_U5: begin
        if (!u6_r) begin
          npx_r  <= hix ? sat32(64'(wmx)) : (lox ? 32'sd0 : px_r);
          npy_r  <= hiy ? sat32(64'(wmy)) : (loy ? 32'sd0 : py_r);
          hitx_r <= hix || lox;
          hity_r <= hiy || loy;
          rpx_r  <= rmx[48:16];
          rpy_r  <= rmy[48:16];
        end
      end
      default: ;
    endcase
  end

  assign in_stall      = (state_r != S_IDLE) || u6_r;
  assign out_valid     = out_valid_r;
  assign out_index     = out_index_r;
  assign out_pos_x     = out_pos_x_r;
  assign out_pos_y     = out_pos_y_r;
  assign out_vel_x     = out_vel_x_r;
  assign out_vel_y     = out_vel_y_r;
  assign out_last_body = out_last_r;

endmodule
